// ===== rtl/core/aps_pkg.sv =====
// ----------------------------------------------------------------------------
// aps_pkg: shared types and constants for the ATA PIO sector sequencer
// Holds the field widths, result kinds, completion codes and the result record
// that the core and its interfaces share.
// ----------------------------------------------------------------------------
package aps_pkg;

	localparam int SECTOR_WORDS = 256;
	localparam int PACKET_BYTES = 2048;
	localparam int SPIN_BITS    = 20;
	localparam int MAX_RESULTS  = 8;

	localparam logic [SPIN_BITS-1:0] SPIN_RESET = SPIN_BITS'(1000000);

	// Request functions.
	localparam logic [1:0] FUNC_REQUEST = 2'd0;
	localparam logic [1:0] FUNC_BUS_RET = 2'd1;
	localparam logic [1:0] FUNC_HOST_WR = 2'd2;

	// Operations.
	localparam logic [1:0] OP_PIO_READ  = 2'd0;
	localparam logic [1:0] OP_PIO_WRITE = 2'd1;
	localparam logic [1:0] OP_PKT_READ  = 2'd2;

	// Result kinds.
	localparam logic [1:0] KIND_BUS  = 2'd0;
	localparam logic [1:0] KIND_RDW  = 2'd1;
	localparam logic [1:0] KIND_WANT = 2'd2;
	localparam logic [1:0] KIND_DONE = 2'd3;

	// Completion codes.
	localparam logic [2:0] DONE_OK       = 3'd0;
	localparam logic [2:0] DONE_BAD_ARGS = 3'd1;
	localparam logic [2:0] DONE_WRONG_DEV = 3'd2;
	localparam logic [2:0] DONE_LBA_RANGE = 3'd3;
	localparam logic [2:0] DONE_BSY_TMO  = 3'd4;
	localparam logic [2:0] DONE_DRQ_FAIL = 3'd5;
	localparam logic [2:0] DONE_RDY_FAIL = 3'd6;
	localparam logic [2:0] DONE_BYTE_CNT = 3'd7;

	// Configuration register indexes.
	localparam logic [1:0] CFG_DRIVE_SLAVE = 2'd0;
	localparam logic [1:0] CFG_SPIN_LIMIT  = 2'd1;
	localparam logic [1:0] CFG_ATAPI       = 2'd2;

	// Task-file register offsets.
	localparam logic [2:0] TF_DATA    = 3'd0;
	localparam logic [2:0] TF_FEATURE = 3'd1;
	localparam logic [2:0] TF_SECCNT  = 3'd2;
	localparam logic [2:0] TF_LBA_LO  = 3'd3;
	localparam logic [2:0] TF_LBA_MID = 3'd4;
	localparam logic [2:0] TF_LBA_HI  = 3'd5;
	localparam logic [2:0] TF_DEVSEL  = 3'd6;
	localparam logic [2:0] TF_CMDSTAT = 3'd7;

	typedef struct packed {
		logic [1:0]  out_kind;
		logic        bus_write;
		logic [2:0]  bus_reg;
		logic [15:0] bus_wdata;
		logic [15:0] host_data;
		logic [2:0]  done_code;
	} res_t;

	function automatic res_t mk_res(logic [1:0] kind, logic wr, logic [2:0] rg,
			logic [15:0] wdata, logic [15:0] hdata, logic [2:0] code);
		res_t r;
		r.out_kind  = kind;
		r.bus_write = wr;
		r.bus_reg   = rg;
		r.bus_wdata = wdata;
		r.host_data = hdata;
		r.done_code = code;
		return r;
	endfunction

endpackage

// ===== rtl/core/aps_if.sv =====
// ----------------------------------------------------------------------------
// aps_if: channel interfaces of the ATA PIO sector sequencer
// Request, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface aps_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [1:0]  op;
	logic [47:0] lba;
	logic [15:0] sector_count;
	logic [15:0] bus_data;
	logic [15:0] host_word;
	modport source (output valid, func, op, lba, sector_count, bus_data, host_word,
		input ready);
	modport sink (input valid, func, op, lba, sector_count, bus_data, host_word,
		output ready);
endinterface

interface aps_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  out_kind;
	logic        bus_write;
	logic [2:0]  bus_reg;
	logic [15:0] bus_wdata;
	logic [15:0] host_data;
	logic [2:0]  done_code;
	logic        out_last;
	modport source (output valid, out_kind, bus_write, bus_reg, bus_wdata, host_data,
		done_code, out_last, input ready);
	modport sink (input valid, out_kind, bus_write, bus_reg, bus_wdata, host_data,
		done_code, out_last, output ready);
endinterface

interface aps_cfg_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                index;
	logic [aps_pkg::SPIN_BITS-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/ata_pio_sector_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// ata_pio_sector_sequencer_core: host-side ATA task-file sequencer
// Runs PIO sector reads and writes and ATAPI READ(12) packet reads, one bus
// access outstanding at a time, and reports a completion code per request.
// ----------------------------------------------------------------------------
//  channel | dir | carries
//  --------+-----+--------------------------------------------------------
//  req     | in  | func, op, lba, sector_count, bus_data, host_word
//  res     | out | out_kind, bus_write, bus_reg, bus_wdata, host_data,
//          |     | done_code, out_last
//  cfg     | in  | index (0 drive_slave, 1 spin_limit, 2 atapi_present), data
//
// An accepted transaction is decoded in the cycle it is taken: the sequencer
// state is updated and all of its results (up to eight) are written into a
// result buffer. The buffer hands out one result per cycle while the result
// channel is ready. The next request transaction is taken in the cycle the
// last result of the previous one is taken. Asynchronous reset clears the
// sequencer to idle, empties the buffer and loads the register defaults. A
// stalled result channel simply holds the buffer.
module ata_pio_sector_sequencer_core (
	input  logic      clk,
	input  logic      arst_n,
	aps_req_if.sink   req,
	aps_res_if.source res,
	aps_cfg_if.sink   cfg
);

	localparam logic [3:0] PH_IDLE   = 4'd0;
	localparam logic [3:0] PH_BSY    = 4'd1;
	localparam logic [3:0] PH_DRQ    = 4'd2;
	localparam logic [3:0] PH_DRQ2   = 4'd3;
	localparam logic [3:0] PH_CNT_HI = 4'd4;
	localparam logic [3:0] PH_CNT_LO = 4'd5;
	localparam logic [3:0] PH_DATA   = 4'd6;
	localparam logic [3:0] PH_WANT   = 4'd7;
	localparam logic [3:0] PH_READY  = 4'd8;

	localparam int SB = aps_pkg::SPIN_BITS;
	localparam logic [10:0] PKT_WORDS = 11'(aps_pkg::PACKET_BYTES / 2);
	localparam logic [10:0] SEC_WORDS = 11'(aps_pkg::SECTOR_WORDS);
	localparam logic [15:0] PKT_BYTES = 16'(aps_pkg::PACKET_BYTES);

	// Configuration registers.
	logic          drive_slave_q;
	logic [SB-1:0] spin_limit_q;
	logic          atapi_q;

	// Sequencer state.
	logic [3:0]    phase_q;
	logic [SB-1:0] spins_q;
	logic [31:0]   cur_blk_q;
	logic [15:0]   blk_left_q;
	logic [10:0]   widx_q;
	logic [1:0]    aop_q;
	logic [7:0]    chb_q;

	// Result buffer.
	aps_pkg::res_t rbuf_q [aps_pkg::MAX_RESULTS];
	logic [2:0]    rd_q;
	logic [3:0]    rem_q;

	// Next state.
	logic [3:0]    phase_d;
	logic [SB-1:0] spins_d;
	logic [31:0]   cur_blk_d;
	logic [15:0]   blk_left_d;
	logic [10:0]   widx_d;
	logic [1:0]    aop_d;
	logic [7:0]    chb_d;
	aps_pkg::res_t rnew [aps_pkg::MAX_RESULTS];
	logic [3:0]    n;

	logic in_acc;
	logic out_acc;

	assign out_acc   = res.valid && res.ready;
	assign req.ready = (rem_q == 4'd0) || (rem_q == 4'd1 && res.ready);
	assign in_acc    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// Decode of one transaction. Waits and completions always come last in a
	// transaction's results, so they are collected as flags and emitted at the end.
	always_comb begin
		logic [7:0]  s;
		logic [10:0] total;
		logic [10:0] w;
		logic [15:0] x;
		logic [7:0]  sel;
		logic        do_wait;
		logic [3:0]  wait_ph;
		logic [2:0]  wait_fail;
		logic        do_fin;
		logic [2:0]  fin_code;
		logic        do_spin;
		logic [2:0]  spin_fail;
		logic        do_next;
		logic [SB-1:0] sp;

		phase_d    = phase_q;
		spins_d    = spins_q;
		cur_blk_d  = cur_blk_q;
		blk_left_d = blk_left_q;
		widx_d     = widx_q;
		aop_d      = aop_q;
		chb_d      = chb_q;
		n          = 4'd0;
		for (int i = 0; i < aps_pkg::MAX_RESULTS; i++) begin
			rnew[i] = '0;
		end
		s         = req.bus_data[7:0];
		total     = (aop_q == aps_pkg::OP_PKT_READ) ? PKT_WORDS : SEC_WORDS;
		w         = widx_q + 11'd1;
		x         = {chb_q, s};
		sel       = {3'b000, drive_slave_q, 4'h0};
		do_wait   = 1'b0;
		wait_ph   = PH_IDLE;
		wait_fail = aps_pkg::DONE_OK;
		do_fin    = 1'b0;
		fin_code  = aps_pkg::DONE_OK;
		do_spin   = 1'b0;
		spin_fail = aps_pkg::DONE_OK;
		do_next   = 1'b0;
		sp        = spins_q - SB'(1);

		if (in_acc) begin
			unique case (req.func)
				aps_pkg::FUNC_REQUEST: begin
					if (phase_q == PH_IDLE) begin
						if (req.sector_count == 16'd0 || req.op > aps_pkg::OP_PKT_READ) begin
							do_fin = 1'b1; fin_code = aps_pkg::DONE_BAD_ARGS;
						end else if ((req.op == aps_pkg::OP_PKT_READ) != atapi_q) begin
							do_fin = 1'b1; fin_code = aps_pkg::DONE_WRONG_DEV;
						end else if ((req.op == aps_pkg::OP_PKT_READ) ? (req.lba[47:32] != 16'd0)
								: (req.lba[47:28] != 20'd0)) begin
							do_fin = 1'b1; fin_code = aps_pkg::DONE_LBA_RANGE;
						end else begin
							aop_d      = req.op;
							cur_blk_d  = req.lba[31:0];
							blk_left_d = req.sector_count;
							widx_d     = 11'd0;
							do_wait = 1'b1; wait_ph = PH_BSY; wait_fail = aps_pkg::DONE_BSY_TMO;
						end
					end
				end
				aps_pkg::FUNC_BUS_RET: begin
					unique case (phase_q)
						PH_BSY: begin
							if (!s[7]) begin
								// Program the task file for the current block.
								if (aop_q == aps_pkg::OP_PKT_READ) begin
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DEVSEL, {8'h00, 8'hA0 | sel}, '0, '0);
									rnew[1] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_FEATURE, '0, '0, '0);
									rnew[2] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_LBA_MID, {8'h00, PKT_BYTES[7:0]}, '0, '0);
									rnew[3] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_LBA_HI, {8'h00, PKT_BYTES[15:8]}, '0, '0);
									rnew[4] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_CMDSTAT, 16'h00A0, '0, '0);
									n = 4'd5;
								end else begin
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DEVSEL,
										{8'h00, 8'hE0 | sel | {4'h0, cur_blk_q[27:24]}}, '0, '0);
									rnew[1] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_FEATURE, '0, '0, '0);
									rnew[2] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_SECCNT, 16'd1, '0, '0);
									rnew[3] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_LBA_LO, {8'h00, cur_blk_q[7:0]}, '0, '0);
									rnew[4] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_LBA_MID, {8'h00, cur_blk_q[15:8]}, '0, '0);
									rnew[5] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_LBA_HI, {8'h00, cur_blk_q[23:16]}, '0, '0);
									rnew[6] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_CMDSTAT,
										(aop_q == aps_pkg::OP_PIO_WRITE) ? 16'h0030 : 16'h0020,
										'0, '0);
									n = 4'd7;
								end
								do_wait = 1'b1; wait_ph = PH_DRQ; wait_fail = aps_pkg::DONE_DRQ_FAIL;
							end else begin
								do_spin = 1'b1; spin_fail = aps_pkg::DONE_BSY_TMO;
							end
						end
						PH_DRQ, PH_DRQ2: begin
							if (s[0] || s[5]) begin
								do_fin = 1'b1; fin_code = aps_pkg::DONE_DRQ_FAIL;
							end else if (!s[7] && s[3]) begin
								widx_d = 11'd0;
								if (phase_q == PH_DRQ2) begin
									phase_d = PH_CNT_HI;
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0,
										aps_pkg::TF_LBA_HI, '0, '0, '0);
									n = 4'd1;
								end else if (aop_q == aps_pkg::OP_PKT_READ) begin
									// READ(12) command packet, six words.
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, 16'h00A8, '0, '0);
									rnew[1] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, {cur_blk_q[23:16], cur_blk_q[31:24]},
										'0, '0);
									rnew[2] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, {cur_blk_q[7:0], cur_blk_q[15:8]},
										'0, '0);
									rnew[3] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, '0, '0, '0);
									rnew[4] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, 16'h0100, '0, '0);
									rnew[5] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1,
										aps_pkg::TF_DATA, '0, '0, '0);
									n = 4'd6;
									do_wait = 1'b1; wait_ph = PH_DRQ2;
									wait_fail = aps_pkg::DONE_DRQ_FAIL;
								end else if (aop_q == aps_pkg::OP_PIO_WRITE) begin
									phase_d = PH_WANT;
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_WANT, 1'b0, '0, '0,
										'0, '0);
									n = 4'd1;
								end else begin
									phase_d = PH_DATA;
									rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0,
										aps_pkg::TF_DATA, '0, '0, '0);
									n = 4'd1;
								end
							end else begin
								do_spin = 1'b1; spin_fail = aps_pkg::DONE_DRQ_FAIL;
							end
						end
						PH_CNT_HI: begin
							chb_d   = s;
							phase_d = PH_CNT_LO;
							rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0,
								aps_pkg::TF_LBA_MID, '0, '0, '0);
							n = 4'd1;
						end
						PH_CNT_LO: begin
							// A zero byte count stands for a full packet.
							if (x != 16'd0 && x != PKT_BYTES) begin
								do_fin = 1'b1; fin_code = aps_pkg::DONE_BYTE_CNT;
							end else begin
								phase_d = PH_DATA;
								rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0,
									aps_pkg::TF_DATA, '0, '0, '0);
								n = 4'd1;
							end
						end
						PH_DATA: begin
							rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_RDW, 1'b0, '0, '0,
								req.bus_data, '0);
							n = 4'd1;
							widx_d = w;
							if (w < total) begin
								rnew[1] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0,
									aps_pkg::TF_DATA, '0, '0, '0);
								n = 4'd2;
							end else if (aop_q == aps_pkg::OP_PIO_READ) begin
								do_next = 1'b1;
							end else begin
								do_wait = 1'b1; wait_ph = PH_READY;
								wait_fail = aps_pkg::DONE_RDY_FAIL;
							end
						end
						PH_READY: begin
							if (s[0] || s[5]) begin
								do_fin = 1'b1; fin_code = aps_pkg::DONE_RDY_FAIL;
							end else if (!s[7]) begin
								do_next = 1'b1;
							end else begin
								do_spin = 1'b1; spin_fail = aps_pkg::DONE_RDY_FAIL;
							end
						end
						default: begin
						end
					endcase
				end
				aps_pkg::FUNC_HOST_WR: begin
					if (phase_q == PH_WANT) begin
						rnew[0] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b1, aps_pkg::TF_DATA,
							req.host_word, '0, '0);
						n = 4'd1;
						widx_d = w;
						if (w < SEC_WORDS) begin
							rnew[1] = aps_pkg::mk_res(aps_pkg::KIND_WANT, 1'b0, '0, '0, '0, '0);
							n = 4'd2;
						end else begin
							do_wait = 1'b1; wait_ph = PH_READY; wait_fail = aps_pkg::DONE_RDY_FAIL;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// Advance to the next block, or complete when none is left.
		if (do_next) begin
			blk_left_d = blk_left_q - 16'd1;
			cur_blk_d  = cur_blk_q + 32'd1;
			if (blk_left_q == 16'd1) begin
				do_fin = 1'b1; fin_code = aps_pkg::DONE_OK;
			end else begin
				do_wait = 1'b1; wait_ph = PH_BSY; wait_fail = aps_pkg::DONE_BSY_TMO;
			end
		end

		// Another status read, or a timeout once the spin budget is used up.
		if (do_spin) begin
			spins_d = sp;
			if (sp == '0) begin
				do_fin = 1'b1; fin_code = spin_fail;
			end else begin
				rnew[n[2:0]] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0, aps_pkg::TF_CMDSTAT,
					'0, '0, '0);
				n = n + 4'd1;
			end
		end

		// Start a status wait; a zero spin limit fails it without a read.
		if (do_wait) begin
			if (spin_limit_q == '0) begin
				do_fin = 1'b1; fin_code = wait_fail;
			end else begin
				spins_d = spin_limit_q;
				phase_d = wait_ph;
				rnew[n[2:0]] = aps_pkg::mk_res(aps_pkg::KIND_BUS, 1'b0, aps_pkg::TF_CMDSTAT,
					'0, '0, '0);
				n = n + 4'd1;
			end
		end

		if (do_fin) begin
			phase_d = PH_IDLE;
			rnew[n[2:0]] = aps_pkg::mk_res(aps_pkg::KIND_DONE, 1'b0, '0, '0, '0, fin_code);
			n = n + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_slave_q <= 1'b0;
			spin_limit_q  <= aps_pkg::SPIN_RESET;
			atapi_q       <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				aps_pkg::CFG_DRIVE_SLAVE: drive_slave_q <= cfg.data[0];
				aps_pkg::CFG_SPIN_LIMIT:  spin_limit_q  <= cfg.data;
				aps_pkg::CFG_ATAPI:       atapi_q       <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			spins_q    <= '0;
			cur_blk_q  <= '0;
			blk_left_q <= '0;
			widx_q     <= '0;
			aop_q      <= '0;
			chb_q      <= '0;
		end else if (in_acc) begin
			phase_q    <= phase_d;
			spins_q    <= spins_d;
			cur_blk_q  <= cur_blk_d;
			blk_left_q <= blk_left_d;
			widx_q     <= widx_d;
			aop_q      <= aop_d;
			chb_q      <= chb_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			rem_q <= '0;
		end else if (in_acc) begin
			rd_q  <= '0;
			rem_q <= n;
		end else if (out_acc) begin
			rd_q  <= rd_q + 3'd1;
			rem_q <= rem_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < aps_pkg::MAX_RESULTS; i++) begin
				rbuf_q[i] <= rnew[i];
			end
		end
	end

	assign res.valid     = (rem_q != 4'd0);
	assign res.out_kind  = rbuf_q[rd_q].out_kind;
	assign res.bus_write = rbuf_q[rd_q].bus_write;
	assign res.bus_reg   = rbuf_q[rd_q].bus_reg;
	assign res.bus_wdata = rbuf_q[rd_q].bus_wdata;
	assign res.host_data = rbuf_q[rd_q].host_data;
	assign res.done_code = rbuf_q[rd_q].done_code;
	assign res.out_last  = (rem_q == 4'd1);

endmodule

// ===== rtl/core/aps_checker.sv =====
// ----------------------------------------------------------------------------
// aps_checker: port-level checks for the ATA PIO sector sequencer
// Watches the request and result channels of the core.
// ----------------------------------------------------------------------------
module aps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [1:0]  res_kind,
	input logic [2:0]  res_code,
	input logic        res_last
);

	// A stalled result stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	// The results of one transaction come without gaps.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid)
		else $error("gap inside a result burst");

	// A request is taken only once the previous results are all handed out.
	a_req_order: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> !res_valid || (res_ready && res_last))
		else $error("request taken with results pending");

	// A completion is always the last result, and only completions carry a code.
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind != aps_pkg::KIND_DONE |-> res_code == aps_pkg::DONE_OK)
		else $error("code on a non-completion result");

	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_kind == aps_pkg::KIND_DONE |-> res_last)
		else $error("completion not last");

endmodule

bind ata_pio_sector_sequencer_core aps_checker u_aps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_kind  (res.out_kind),
	.res_code  (res.done_code),
	.res_last  (res.out_last)
);

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for the ATA PIO sector sequencer core
// Acts as host and drive: it sends requests, bus read returns and host write
// words, mirrors the sequencer in a scoreboard and checks every result record.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aps_pkg::*;

	// Sequencer phases as the scoreboard tracks them.
	typedef enum logic [3:0] {
		SEQ_IDLE, SEQ_BSY, SEQ_DRQ, SEQ_DRQ2, SEQ_CNT_HI, SEQ_CNT_LO,
		SEQ_DATA, SEQ_WANT, SEQ_READY
	} seq_phase_e;

	// Status register bits.
	localparam logic [7:0] STS_ERR = 8'h01;
	localparam logic [7:0] STS_DRQ = 8'h08;
	localparam logic [7:0] STS_DF  = 8'h20;
	localparam logic [7:0] STS_BSY = 8'h80;
	localparam logic [7:0] STS_RDY_DRQ = 8'h58;
	localparam logic [7:0] STS_RDY = 8'h50;
	localparam logic [1:0] FUNC_NONE = 2'd3;
	localparam logic [1:0] OP_NONE   = 2'd3;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;

	typedef struct {
		logic [1:0]  func;
		logic [1:0]  op;
		logic [47:0] lba;
		logic [15:0] sector_count;
		logic [15:0] bus_data;
		logic [15:0] host_word;
	} host_item_t;

	// The scoreboard keeps its own copy of the sequencer and the queue of
	// result records that the core still owes.
	class seq_scoreboard;
		logic              drive_slave;
		logic [SPIN_BITS-1:0] spin_limit;
		logic              atapi;
		seq_phase_e        ph;
		logic [SPIN_BITS-1:0] spins_left;
		logic [31:0]       cur_block;
		logic [15:0]       blocks_left;
		logic [10:0]       word_idx;
		logic [1:0]        act_op;
		logic [7:0]        cnt_hi;
		res_t              step_res[$];
		res_t              owed_res[$];
		bit                owed_last[$];
		int                errors;

		function new();
			drive_slave = 1'b0;
			spin_limit  = SPIN_RESET;
			atapi       = 1'b0;
			ph          = SEQ_IDLE;
			spins_left  = '0;
			cur_block   = '0;
			blocks_left = '0;
			word_idx    = '0;
			act_op      = OP_PIO_READ;
			cnt_hi      = '0;
			errors      = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [SPIN_BITS-1:0] val);
			case (idx)
				CFG_DRIVE_SLAVE: drive_slave = val[0];
				CFG_SPIN_LIMIT:  spin_limit = val;
				CFG_ATAPI:       atapi = val[0];
				default: ;
			endcase
		endfunction

		function void push(res_t r);
			if (step_res.size() < MAX_RESULTS)
				step_res.push_back(r);
		endfunction

		function void bus_rd(logic [2:0] rg);
			push(mk_res(KIND_BUS, 1'b0, rg, 16'h0, 16'h0, DONE_OK));
		endfunction

		function void bus_wr(logic [2:0] rg, logic [15:0] v);
			push(mk_res(KIND_BUS, 1'b1, rg, v, 16'h0, DONE_OK));
		endfunction

		function void complete(logic [2:0] code);
			push(mk_res(KIND_DONE, 1'b0, 3'd0, 16'h0, 16'h0, code));
			ph = SEQ_IDLE;
		endfunction

		// A status wait with a zero spin limit fails without any status read.
		function void start_wait(seq_phase_e p, logic [2:0] code);
			if (spin_limit == 0) begin
				complete(code);
				return;
			end
			spins_left = spin_limit;
			ph = p;
			bus_rd(TF_CMDSTAT);
		endfunction

		function void poll_again(logic [2:0] code);
			spins_left = spins_left - 1'b1;
			if (spins_left == 0)
				complete(code);
			else
				bus_rd(TF_CMDSTAT);
		endfunction

		function void advance_block();
			blocks_left = blocks_left - 1'b1;
			cur_block = cur_block + 1;
			if (blocks_left == 0)
				complete(DONE_OK);
			else
				start_wait(SEQ_BSY, DONE_BSY_TMO);
		endfunction

		function void write_taskfile();
			logic [7:0] sel;
			sel = {3'b000, drive_slave, 4'h0};
			if (act_op == OP_PKT_READ) begin
				bus_wr(TF_DEVSEL, {8'h00, 8'hA0 | sel});
				bus_wr(TF_FEATURE, 16'h0);
				bus_wr(TF_LBA_MID, 16'(PACKET_BYTES & 8'hFF));
				bus_wr(TF_LBA_HI, 16'((PACKET_BYTES >> 8) & 8'hFF));
				bus_wr(TF_CMDSTAT, 16'h00A0);
			end else begin
				bus_wr(TF_DEVSEL, {8'h00, 8'hE0 | sel | {4'h0, cur_block[27:24]}});
				bus_wr(TF_FEATURE, 16'h0);
				bus_wr(TF_SECCNT, 16'h1);
				bus_wr(TF_LBA_LO, {8'h00, cur_block[7:0]});
				bus_wr(TF_LBA_MID, {8'h00, cur_block[15:8]});
				bus_wr(TF_LBA_HI, {8'h00, cur_block[23:16]});
				bus_wr(TF_CMDSTAT, act_op == OP_PIO_WRITE ? 16'h0030 : 16'h0020);
			end
			start_wait(SEQ_DRQ, DONE_DRQ_FAIL);
		endfunction

		// READ(12) command block, one block at a time, big-endian address.
		function void write_packet();
			bus_wr(TF_DATA, 16'h00A8);
			bus_wr(TF_DATA, {cur_block[23:16], cur_block[31:24]});
			bus_wr(TF_DATA, {cur_block[7:0], cur_block[15:8]});
			bus_wr(TF_DATA, 16'h0);
			bus_wr(TF_DATA, 16'h0100);
			bus_wr(TF_DATA, 16'h0);
			start_wait(SEQ_DRQ2, DONE_DRQ_FAIL);
		endfunction

		function void take_request(host_item_t it);
			if (it.sector_count == 0 || it.op > OP_PKT_READ) begin
				complete(DONE_BAD_ARGS);
				return;
			end
			if ((it.op == OP_PKT_READ) != atapi) begin
				complete(DONE_WRONG_DEV);
				return;
			end
			if (it.lba > (it.op == OP_PKT_READ ? 48'hFFFF_FFFF : 48'h0FFF_FFFF)) begin
				complete(DONE_LBA_RANGE);
				return;
			end
			act_op = it.op;
			cur_block = it.lba[31:0];
			blocks_left = it.sector_count;
			word_idx = '0;
			start_wait(SEQ_BSY, DONE_BSY_TMO);
		endfunction

		function void take_return(logic [15:0] d);
			logic [7:0]  s;
			logic [11:0] words;
			logic [15:0] bytes;
			s = d[7:0];
			words = act_op == OP_PKT_READ ? 12'(PACKET_BYTES / 2) : 12'(SECTOR_WORDS);
			case (ph)
				SEQ_BSY: begin
					if ((s & STS_BSY) == 0)
						write_taskfile();
					else
						poll_again(DONE_BSY_TMO);
				end
				SEQ_DRQ, SEQ_DRQ2: begin
					// Error and device fault win even while busy is still set.
					if ((s & (STS_ERR | STS_DF)) != 0)
						complete(DONE_DRQ_FAIL);
					else if ((s & STS_BSY) == 0 && (s & STS_DRQ) != 0) begin
						word_idx = '0;
						if (ph == SEQ_DRQ2) begin
							ph = SEQ_CNT_HI;
							bus_rd(TF_LBA_HI);
						end else if (act_op == OP_PKT_READ)
							write_packet();
						else if (act_op == OP_PIO_WRITE) begin
							ph = SEQ_WANT;
							push(mk_res(KIND_WANT, 1'b0, 3'd0, 16'h0, 16'h0, DONE_OK));
						end else begin
							ph = SEQ_DATA;
							bus_rd(TF_DATA);
						end
					end else
						poll_again(DONE_DRQ_FAIL);
				end
				SEQ_CNT_HI: begin
					cnt_hi = s;
					ph = SEQ_CNT_LO;
					bus_rd(TF_LBA_MID);
				end
				SEQ_CNT_LO: begin
					// A zero byte count stands for a full packet.
					bytes = {cnt_hi, s};
					if (bytes == 0)
						bytes = 16'(PACKET_BYTES);
					if (bytes != 16'(PACKET_BYTES))
						complete(DONE_BYTE_CNT);
					else begin
						ph = SEQ_DATA;
						bus_rd(TF_DATA);
					end
				end
				SEQ_DATA: begin
					push(mk_res(KIND_RDW, 1'b0, 3'd0, 16'h0, d, DONE_OK));
					word_idx = word_idx + 1'b1;
					if (word_idx < words)
						bus_rd(TF_DATA);
					else if (act_op == OP_PIO_READ)
						advance_block();
					else
						start_wait(SEQ_READY, DONE_RDY_FAIL);
				end
				SEQ_READY: begin
					if ((s & (STS_ERR | STS_DF)) != 0)
						complete(DONE_RDY_FAIL);
					else if ((s & STS_BSY) == 0)
						advance_block();
					else
						poll_again(DONE_RDY_FAIL);
				end
				default: ;
			endcase
		endfunction

		// Returns the number of result records that the transaction causes.
		function int note_input(host_item_t it);
			step_res.delete();
			case (it.func)
				FUNC_REQUEST: if (ph == SEQ_IDLE) take_request(it);
				FUNC_BUS_RET: if (ph != SEQ_IDLE && ph != SEQ_WANT) take_return(it.bus_data);
				FUNC_HOST_WR: begin
					if (ph == SEQ_WANT) begin
						bus_wr(TF_DATA, it.host_word);
						word_idx = word_idx + 1'b1;
						if (word_idx < 11'(SECTOR_WORDS))
							push(mk_res(KIND_WANT, 1'b0, 3'd0, 16'h0, 16'h0, DONE_OK));
						else
							start_wait(SEQ_READY, DONE_RDY_FAIL);
					end
				end
				default: ;
			endcase
			foreach (step_res[i]) begin
				owed_res.push_back(step_res[i]);
				owed_last.push_back(i == step_res.size() - 1);
			end
			return step_res.size();
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $realtime, what);
			errors++;
		endtask

		task check_result(res_t got, bit last);
			res_t e;
			bit   el;
			if (owed_res.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			e = owed_res.pop_front();
			el = owed_last.pop_front();
			if (got.out_kind !== e.out_kind)
				report($sformatf("out_kind %0d, want %0d", got.out_kind, e.out_kind));
			if (got.bus_write !== e.bus_write)
				report($sformatf("bus_write %0d, want %0d", got.bus_write, e.bus_write));
			if (got.bus_reg !== e.bus_reg)
				report($sformatf("bus_reg %0d, want %0d", got.bus_reg, e.bus_reg));
			if (got.bus_wdata !== e.bus_wdata)
				report($sformatf("bus_wdata %h, want %h", got.bus_wdata, e.bus_wdata));
			if (got.host_data !== e.host_data)
				report($sformatf("host_data %h, want %h", got.host_data, e.host_data));
			if (got.done_code !== e.done_code)
				report($sformatf("done_code %0d, want %0d", got.done_code, e.done_code));
			if (last !== el)
				report($sformatf("out_last %0d, want %0d", last, el));
		endtask
	endclass

	logic clk;
	logic arst_n;
	aps_req_if req_if ();
	aps_res_if res_if ();
	aps_cfg_if cfg_if ();

	ata_pio_sector_sequencer_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if),
		.cfg    (cfg_if)
	);

	seq_scoreboard sb = new();

	// Idling rates in percent and the one-off long hold-off of the result side.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_len = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every input starts at a known value while reset is held.
	initial begin
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= FUNC_REQUEST;
		req_if.op <= OP_PIO_READ;
		req_if.lba <= '0;
		req_if.sector_count <= '0;
		req_if.bus_data <= '0;
		req_if.host_word <= '0;
		res_if.ready <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.index <= CFG_DRIVE_SLAVE;
		cfg_if.data <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Result side: random stalls, plus one long hold-off when asked. The hold
	// is counted here so that the sender keeps offering while results back up.
	initial begin
		@(posedge arst_n);
		forever begin
			if (hold_len > 0) begin
				res_if.ready <= 1'b0;
				repeat (hold_len) @(posedge clk);
				hold_len = 0;
			end
			res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (res_if.valid && res_if.ready)
				sb.check_result(res_t'{res_if.out_kind, res_if.bus_write, res_if.bus_reg,
					res_if.bus_wdata, res_if.host_data, res_if.done_code}, res_if.out_last);
		end
	end

	// The watchdog ends the run when no channel moves a transaction for too long.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
				(cfg_if.valid && cfg_if.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic host_item_t mk_item(logic [1:0] func, logic [1:0] op,
			logic [47:0] lba, logic [15:0] cnt, logic [15:0] bd, logic [15:0] hw);
		host_item_t it;
		it.func = func;
		it.op = op;
		it.lba = lba;
		it.sector_count = cnt;
		it.bus_data = bd;
		it.host_word = hw;
		return it;
	endfunction

	// Sends one transaction and hands it to the scoreboard once it is taken.
	// Returns the number of results it causes.
	task automatic send_item(host_item_t it, output int n);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.func <= it.func;
		req_if.op <= it.op;
		req_if.lba <= it.lba;
		req_if.sector_count <= it.sector_count;
		req_if.bus_data <= it.bus_data;
		req_if.host_word <= it.host_word;
		do @(posedge clk); while (!req_if.ready);
		n = sb.note_input(it);
	endtask

	// Leaves valid high so that back-to-back writes need no gap.
	task automatic cfg_write(logic [1:0] idx, logic [SPIN_BITS-1:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		sb.set_reg(idx, val);
	endtask

	// Waits for every owed result, then waits on so that an item that caused
	// none can clear the core.
	task automatic wait_quiet();
		req_if.valid <= 1'b0;
		while (sb.owed_res.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic setup(logic slave, logic [SPIN_BITS-1:0] spins, logic pkt);
		wait_quiet();
		cfg_write(CFG_DRIVE_SLAVE, slave);
		cfg_write(CFG_SPIN_LIMIT, spins);
		cfg_write(CFG_ATAPI, pkt);
		cfg_if.valid <= 1'b0;
	endtask

	// Plays the drive: the next transaction follows from the phase the
	// scoreboard is in. In clean mode every status is the good one; otherwise
	// statuses go bad now and then, stray transactions are mixed in, and the
	// drive never lets a request reach its data phase.
	function automatic host_item_t next_item(bit clean);
		host_item_t it;
		logic [15:0] r;
		int roll;
		r = 16'($urandom);
		roll = $urandom_range(99);
		it = mk_item(FUNC_BUS_RET, 2'($urandom), {16'($urandom), 32'($urandom)},
			16'($urandom), r, 16'($urandom));
		if (!clean && sb.ph != SEQ_IDLE && roll < 3) begin
			// A stray request while busy, or an unused function code.
			it.func = roll < 2 ? FUNC_REQUEST : FUNC_NONE;
			return it;
		end
		case (sb.ph)
			SEQ_IDLE: begin
				if (roll < 8) begin
					it.func = roll < 3 ? FUNC_BUS_RET : (roll < 6 ? FUNC_HOST_WR : FUNC_NONE);
					return it;
				end
				it.func = FUNC_REQUEST;
				if ($urandom_range(99) < 85)
					it.op = sb.atapi ? OP_PKT_READ : 2'($urandom_range(1));
				it.sector_count = $urandom_range(99) < 90 ? 16'd1 : 16'($urandom_range(3, 2));
				if ($urandom_range(99) < 4)
					it.sector_count = 16'd0;
				roll = $urandom_range(99);
				if (roll < 70)
					it.lba = it.op == OP_PKT_READ ? 48'($urandom) : 48'($urandom & 32'h0FFF_FFFF);
				else if (roll < 90)
					it.lba = it.op == OP_PKT_READ ? 48'hFFFF_FFFF - $urandom_range(1)
						: 48'h0FFF_FFFF - $urandom_range(1);
			end
			SEQ_BSY, SEQ_READY: begin
				if (clean || roll >= 30)
					it.bus_data = {r[15:8], STS_RDY & ~(STS_ERR | STS_DF)};
				else if (roll < 8 && sb.ph == SEQ_READY)
					it.bus_data = {r[15:8], r[7:0] | STS_ERR};
				else
					it.bus_data = {r[15:8], r[7:0] | STS_BSY};
			end
			SEQ_DRQ, SEQ_DRQ2: begin
				// Outside clean mode a PIO request never gets its data request.
				if (clean || (roll >= 25 && (sb.ph == SEQ_DRQ2 || sb.act_op == OP_PKT_READ)))
					it.bus_data = {r[15:8], STS_RDY_DRQ};
				else if (roll < 8)
					it.bus_data = {r[15:8], r[7:0] | (roll < 4 ? STS_ERR : STS_DF)};
				else
					it.bus_data = {r[15:8], r[7:0] & ~(STS_ERR | STS_DF) & ~STS_DRQ};
			end
			SEQ_CNT_HI:
				it.bus_data = {r[15:8], clean || roll >= 10 ? 8'h08
					: (roll < 5 ? 8'h00 : r[7:0])};
			SEQ_CNT_LO:
				it.bus_data = {r[15:8], clean ? 8'h00 : (r[7:0] | 8'h01)};
			SEQ_WANT: it.func = (!clean && roll < 6) ? FUNC_BUS_RET : FUNC_HOST_WR;
			default: ;
		endcase
		return it;
	endfunction

	task automatic finish_request();
		int n;
		while (sb.ph != SEQ_IDLE)
			send_item(next_item(1'b1), n);
	endtask

	// Ends the open request early: DRQ and ready waits get an error, a low
	// count byte gets a wrong count, and the rest gets the clean answer.
	task automatic abort_request();
		int n;
		host_item_t it;
		while (sb.ph != SEQ_IDLE) begin
			it = next_item(1'b1);
			case (sb.ph)
				SEQ_DRQ, SEQ_DRQ2, SEQ_READY: it.bus_data = {8'h00, STS_ERR};
				SEQ_CNT_LO: it.bus_data = 16'h0001;
				default: ;
			endcase
			send_item(it, n);
		end
	endtask

	// Random traffic for a set number of transactions, then the open request
	// is brought to an early end.
	task automatic run_random(int target, bit pressure);
		int n;
		int sent;
		sent = 0;
		while (sent < target) begin
			if (pressure && sent == 5)
				hold_len = HOLD_CYCLES;
			send_item(next_item(1'b0), n);
			sent++;
		end
		abort_request();
	endtask

	task automatic run_list(host_item_t lst[$]);
		int n;
		foreach (lst[i])
			send_item(lst[i], n);
	endtask

	initial begin
		host_item_t lst[$];
		@(posedge arst_n);
		@(posedge clk);

		// Argument checks in order, then a PIO read that dies on a drive fault.
		setup(1'b0, SPIN_RESET, 1'b0);
		lst = '{
			mk_item(FUNC_REQUEST, OP_PIO_READ, 48'h0, 16'd0, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_NONE, 48'h0, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PKT_READ, 48'h0, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PIO_READ, 48'h1000_0000, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PIO_WRITE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PIO_READ, 48'h0FFF_FFFF, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0080, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'hFF50, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h00A1, 16'h0),
			// PIO write: busy with DRQ still polls, stray items are dropped.
			mk_item(FUNC_REQUEST, OP_PIO_WRITE, 48'h0ABC_DEF1, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0050, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0088, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0058, 16'h0),
			mk_item(FUNC_REQUEST, OP_PIO_READ, 48'h0, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'hFFFF, 16'h0),
			mk_item(FUNC_NONE, OP_PIO_READ, 48'h0, 16'd0, 16'h0, 16'hFFFF),
			mk_item(FUNC_HOST_WR, OP_PIO_READ, 48'h0, 16'd0, 16'h0, 16'hFFFF),
			mk_item(FUNC_HOST_WR, OP_PIO_READ, 48'h0, 16'd0, 16'h0, 16'h0000)
		};
		run_list(lst);
		finish_request();

		// Packet device with a zero spin limit: waits fail without a poll.
		setup(1'b1, '0, 1'b1);
		lst = '{
			mk_item(FUNC_REQUEST, OP_PKT_READ, 48'h0, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PIO_READ, 48'h0, 16'd1, 16'h0, 16'h0),
			mk_item(FUNC_REQUEST, OP_PKT_READ, 48'h1_0000_0000, 16'd1, 16'h0, 16'h0)
		};
		run_list(lst);

		// Busy timeout after two polls, then a packet read at the top block
		// whose drive reports a byte count one above a full packet.
		setup(1'b1, 20'd2, 1'b1);
		lst = '{
			mk_item(FUNC_REQUEST, OP_PKT_READ, 48'hFFFF_FFFF, 16'd2, 16'h0, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0080, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0080, 16'h0),
			mk_item(FUNC_REQUEST, OP_PKT_READ, 48'hFFFF_FFFF, 16'd2, 16'h0, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0000, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0058, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0058, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0008, 16'h0),
			mk_item(FUNC_BUS_RET, OP_PIO_READ, 48'h0, 16'd0, 16'h0001, 16'h0)
		};
		run_list(lst);
		finish_request();

		// Random phases, each under its own register setting and idling mix.
		setup(1'b0, 20'hF_FFFF, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		run_random(15, 1'b0);

		setup(1'b1, 20'd1, 1'b1);
		send_idle_pct = 50;
		recv_stall_pct = 0;
		run_random(15, 1'b0);

		setup(1'b1, 20'd3, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 50;
		run_random(15, 1'b1);

		setup(1'b0, SPIN_RESET, 1'b1);
		send_idle_pct = 31;
		recv_stall_pct = 31;
		run_random(15, 1'b0);

		wait_quiet();
		repeat (20) @(posedge clk);
		if (sb.owed_res.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.owed_res.size()));
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== ata_pio_sector_sequencer_core.f =====
rtl/core/aps_pkg.sv
rtl/core/aps_if.sv
rtl/core/ata_pio_sector_sequencer_core.sv
rtl/core/aps_checker.sv
bench/tb.sv
